### hdl/tlfu_pkg.sv
// ----------------------------------------------------------------------------
// tlfu_pkg
// Shared sizes, types and codes of the three-tier frequency-replacement store.
// ----------------------------------------------------------------------------
package tlfu_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int PAGE_ENTRIES  = 32;
  localparam int DISK_ENTRIES  = 64;
  localparam int ADDRESS_IDS   = 256;
  localparam int COUNT_BITS    = 16;

  localparam int IN_W    = 8;
  localparam int LAT_W   = 10;
  localparam int ID_W    = (ADDRESS_IDS > 256) ? IN_W : $clog2(ADDRESS_IDS);
  localparam int CNT_DEPTH = 1 << ID_W;

  // all three lists share one memory: cache, then page, then disk
  localparam int LM_DEPTH = CACHE_ENTRIES + PAGE_ENTRIES + DISK_ENTRIES;
  localparam int LM_AW    = $clog2(LM_DEPTH);
  localparam int FILL_W   = $clog2(DISK_ENTRIES + 1);

  typedef logic [ID_W-1:0]       id_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [LAT_W-1:0]      lat_t;

  typedef enum logic [1:0] {
    CFG_CACHE_LAT = 2'd0,
    CFG_PAGE_LAT  = 2'd1,
    CFG_DISK_LAT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TIER_CACHE = 2'd0,
    TIER_PAGE  = 2'd1,
    TIER_DISK  = 2'd2,
    TIER_NONE  = 2'd3
  } tier_t;

  typedef logic [255:0][ID_W-1:0] id_map_t;

  function automatic id_map_t build_id_map();
    id_map_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = ID_W'(i % ADDRESS_IDS);
    end
    return t;
  endfunction

  // folds a raw identifier into the id range
  localparam id_map_t ID_MAP = build_id_map();

endpackage

### hdl/tlfu_cnt_store.sv
// ----------------------------------------------------------------------------
// tlfu_cnt_store
// Per-id use counters: one write and one registered read port, with a valid
// bit per entry so an entry never written reads as zero after reset.
// ----------------------------------------------------------------------------
module tlfu_cnt_store (
  input  logic            clk,
  input  logic            rst_n,
  input  tlfu_pkg::id_t   rd_addr,
  output tlfu_pkg::cnt_t  rd_data,
  input  logic            wr_en,
  input  tlfu_pkg::id_t   wr_addr,
  input  tlfu_pkg::cnt_t  wr_data
);
  import tlfu_pkg::*;

  cnt_t                 mem [CNT_DEPTH];
  logic [CNT_DEPTH-1:0] vld_r;
  cnt_t                 rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/three_tier_lfu_storage.sv
// ----------------------------------------------------------------------------
// three_tier_lfu_storage
// Cache / page / disk tier lookup with frequency replacement and promotion.
// ----------------------------------------------------------------------------
// Sequencing: all work goes through the single list memory port; list scans,
//   minimum searches and shifts each walk a list one entry at a time.
// Items: one is in work at a time; the next is taken while a result waits.
// Reset: synchronous; a preload sweep over all LM_DEPTH list entries (112 by default)
//   writes the initial lists, the input stalls until it ends.
module three_tier_lfu_storage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_address_id,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_tier_found,
  output logic [9:0]             out_latency,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [9:0]             cfg_data
);
  import tlfu_pkg::*;

  typedef enum logic [3:0] {
    S_PRELOAD, S_IDLE, S_CNT_RD, S_CNT_WR, S_SCAN_RD, S_SCAN_CMP,
    S_LST_RD, S_LST_CNT, S_LST_CMP, S_DEL_RD, S_DEL_WR, S_NEXT, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ST_SCAN_C, ST_SCAN_P, ST_SCAN_D, ST_TP_DEL, ST_TP_LST,
    ST_TC_DEL, ST_TC_LST, ST_TC_VDEL
  } step_t;

  typedef enum logic [1:0] {L_CACHE, L_PAGE, L_DISK} list_t;

  localparam logic [LM_AW-1:0]  BASE_CACHE = '0;
  localparam logic [LM_AW-1:0]  BASE_PAGE  = LM_AW'(CACHE_ENTRIES);
  localparam logic [LM_AW-1:0]  BASE_DISK  = LM_AW'(CACHE_ENTRIES + PAGE_ENTRIES);
  localparam logic [LM_AW-1:0]  PRE_LAST   = LM_AW'(LM_DEPTH - 1);
  localparam logic [FILL_W-1:0] CAP_C      = FILL_W'(CACHE_ENTRIES);
  localparam logic [FILL_W-1:0] CAP_P      = FILL_W'(PAGE_ENTRIES);
  localparam logic [FILL_W-1:0] CAP_D      = FILL_W'(DISK_ENTRIES);
  localparam cnt_t              CNT_MAX    = '1;

  state_t state_r, state_nxt;
  step_t  stp_r, stp_nxt;
  list_t  sel_r, sel_nxt;
  id_t    id_r, id_nxt;
  tier_t  tier_r, tier_nxt;
  logic   found_r, found_nxt;
  logic [FILL_W-1:0] i_r, i_nxt;
  logic [FILL_W-1:0] pos_r, pos_nxt;
  logic [FILL_W-1:0] best_pos_r, best_pos_nxt;
  cnt_t   best_cnt_r, best_cnt_nxt;
  id_t    best_id_r, best_id_nxt;
  id_t    cand_id_r, cand_id_nxt;
  logic [FILL_W-1:0] cfill_r, cfill_nxt;
  logic [FILL_W-1:0] pfill_r, pfill_nxt;
  logic [FILL_W-1:0] dfill_r, dfill_nxt;
  logic [LM_AW-1:0]  pre_addr_r, pre_addr_nxt;
  logic   out_valid_r, out_valid_nxt;
  tier_t  out_tier_r, out_tier_nxt;
  lat_t   out_lat_r, out_lat_nxt;
  lat_t   cache_lat_r, cache_lat_nxt;
  lat_t   page_lat_r, page_lat_nxt;
  lat_t   disk_lat_r, disk_lat_nxt;

  // list memory
  id_t              lm_mem [LM_DEPTH];
  id_t              lm_rdata_r;
  logic             lm_we;
  logic [LM_AW-1:0] lm_waddr;
  logic [LM_AW-1:0] lm_raddr;
  id_t              lm_wdata;

  // counter store
  id_t  cnt_raddr;
  cnt_t cnt_rdata;
  logic cnt_we;
  cnt_t cnt_wdata;

  logic [FILL_W-1:0] cur_fill;
  logic [LM_AW-1:0]  cur_base;
  logic [LM_AW-1:0]  pre_val;

  tlfu_cnt_store u_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (cnt_raddr),
    .rd_data (cnt_rdata),
    .wr_en   (cnt_we),
    .wr_addr (id_r),
    .wr_data (cnt_wdata)
  );

  always_ff @(posedge clk) begin
    if (lm_we) begin
      lm_mem[lm_waddr] <= lm_wdata;
    end
    lm_rdata_r <= lm_mem[lm_raddr];
  end

  always_comb begin
    unique case (sel_r)
      L_CACHE: begin cur_fill = cfill_r; cur_base = BASE_CACHE; end
      L_PAGE:  begin cur_fill = pfill_r; cur_base = BASE_PAGE;  end
      L_DISK:  begin cur_fill = dfill_r; cur_base = BASE_DISK;  end
      default: begin cur_fill = dfill_r; cur_base = BASE_DISK;  end
    endcase
  end

  // preload value: cache and page ids equal their address, disk ids sit CACHE below it
  assign pre_val = (pre_addr_r < BASE_DISK) ? pre_addr_r : (pre_addr_r - BASE_PAGE);

  always_comb begin
    state_nxt     = state_r;
    stp_nxt       = stp_r;
    sel_nxt       = sel_r;
    id_nxt        = id_r;
    tier_nxt      = tier_r;
    found_nxt     = found_r;
    i_nxt         = i_r;
    pos_nxt       = pos_r;
    best_pos_nxt  = best_pos_r;
    best_cnt_nxt  = best_cnt_r;
    best_id_nxt   = best_id_r;
    cand_id_nxt   = cand_id_r;
    cfill_nxt     = cfill_r;
    pfill_nxt     = pfill_r;
    dfill_nxt     = dfill_r;
    pre_addr_nxt  = pre_addr_r;
    out_valid_nxt = out_valid_r;
    out_tier_nxt  = out_tier_r;
    out_lat_nxt   = out_lat_r;
    cache_lat_nxt = cache_lat_r;
    page_lat_nxt  = page_lat_r;
    disk_lat_nxt  = disk_lat_r;
    lm_we         = 1'b0;
    lm_waddr      = cur_base + LM_AW'(pos_r);
    lm_wdata      = lm_rdata_r;
    lm_raddr      = cur_base + LM_AW'(i_r);
    cnt_raddr     = lm_rdata_r;
    cnt_we        = 1'b0;
    cnt_wdata     = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CACHE_LAT: cache_lat_nxt = cfg_data;
        CFG_PAGE_LAT:  page_lat_nxt  = cfg_data;
        CFG_DISK_LAT:  disk_lat_nxt  = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_PRELOAD: begin
        lm_we    = 1'b1;
        lm_waddr = pre_addr_r;
        lm_wdata = ID_MAP[8'(pre_val)];
        if (pre_addr_r == PRE_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          pre_addr_nxt = pre_addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          id_nxt    = ID_MAP[in_address_id];
          state_nxt = S_CNT_RD;
        end
      end

      S_CNT_RD: begin
        cnt_raddr = id_r;
        state_nxt = S_CNT_WR;
      end

      S_CNT_WR: begin
        cnt_we    = 1'b1;
        sel_nxt   = L_CACHE;
        i_nxt     = '0;
        stp_nxt   = ST_SCAN_C;
        state_nxt = S_SCAN_RD;
      end

      S_SCAN_RD: begin
        if (i_r >= cur_fill) begin
          found_nxt = 1'b0;
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (lm_rdata_r == id_r) begin
          found_nxt = 1'b1;
          pos_nxt   = i_r;
          state_nxt = S_NEXT;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end

      S_LST_RD: begin
        state_nxt = (i_r >= cur_fill) ? S_NEXT : S_LST_CNT;
      end

      S_LST_CNT: begin
        cand_id_nxt = lm_rdata_r;
        state_nxt   = S_LST_CMP;
      end

      S_LST_CMP: begin
        // strict compare keeps the earliest position on a tie
        if (i_r == '0 || cnt_rdata < best_cnt_r) begin
          best_cnt_nxt = cnt_rdata;
          best_pos_nxt = i_r;
          best_id_nxt  = cand_id_r;
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_LST_RD;
      end

      S_DEL_RD: begin
        lm_raddr = cur_base + LM_AW'(pos_r) + LM_AW'(1);
        if ({1'b0, pos_r} + 1'b1 >= {1'b0, cur_fill}) begin
          unique case (sel_r)
            L_CACHE: cfill_nxt = cfill_r - 1'b1;
            L_PAGE:  pfill_nxt = pfill_r - 1'b1;
            default: dfill_nxt = dfill_r - 1'b1;
          endcase
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_DEL_WR;
        end
      end

      S_DEL_WR: begin
        // close the gap one entry at a time
        lm_we     = 1'b1;
        pos_nxt   = pos_r + 1'b1;
        state_nxt = S_DEL_RD;
      end

      S_NEXT: begin
        unique case (stp_r)
          ST_SCAN_C: begin
            if (found_r) begin
              tier_nxt  = TIER_CACHE;
              state_nxt = S_DONE;
            end else begin
              sel_nxt   = L_PAGE;
              i_nxt     = '0;
              stp_nxt   = ST_SCAN_P;
              state_nxt = S_SCAN_RD;
            end
          end

          ST_SCAN_P: begin
            if (found_r) begin
              tier_nxt  = TIER_PAGE;
              stp_nxt   = ST_TC_DEL;
              state_nxt = S_DEL_RD;
            end else begin
              sel_nxt   = L_DISK;
              i_nxt     = '0;
              stp_nxt   = ST_SCAN_D;
              state_nxt = S_SCAN_RD;
            end
          end

          ST_SCAN_D: begin
            // an absent id would be appended to disk and pulled out again:
            // skip both, only the drop of the oldest entry remains
            tier_nxt  = found_r ? TIER_DISK : TIER_NONE;
            sel_nxt   = L_DISK;
            stp_nxt   = ST_TP_DEL;
            if (found_r || dfill_r >= CAP_D) begin
              if (!found_r) begin
                pos_nxt = '0;
              end
              state_nxt = S_DEL_RD;
            end else begin
              state_nxt = S_NEXT;
            end
          end

          ST_TP_DEL: begin
            if (pfill_r >= CAP_P) begin
              sel_nxt   = L_PAGE;
              i_nxt     = '0;
              stp_nxt   = ST_TP_LST;
              state_nxt = S_LST_RD;
            end else begin
              stp_nxt   = ST_TC_DEL;
              state_nxt = S_NEXT;
            end
          end

          ST_TP_LST: begin
            if (dfill_r < CAP_D) begin
              lm_we     = 1'b1;
              lm_waddr  = BASE_DISK + LM_AW'(dfill_r);
              lm_wdata  = best_id_r;
              dfill_nxt = dfill_r + 1'b1;
            end
            sel_nxt   = L_PAGE;
            pos_nxt   = best_pos_r;
            stp_nxt   = ST_TC_DEL;
            state_nxt = S_DEL_RD;
          end

          ST_TC_DEL: begin
            if (cfill_r >= CAP_C) begin
              sel_nxt   = L_CACHE;
              i_nxt     = '0;
              stp_nxt   = ST_TC_LST;
              state_nxt = S_LST_RD;
            end else begin
              stp_nxt   = ST_TC_VDEL;
              state_nxt = S_NEXT;
            end
          end

          ST_TC_LST: begin
            if (pfill_r < CAP_P) begin
              lm_we     = 1'b1;
              lm_waddr  = BASE_PAGE + LM_AW'(pfill_r);
              lm_wdata  = best_id_r;
              pfill_nxt = pfill_r + 1'b1;
            end
            sel_nxt   = L_CACHE;
            pos_nxt   = best_pos_r;
            stp_nxt   = ST_TC_VDEL;
            state_nxt = S_DEL_RD;
          end

          ST_TC_VDEL: begin
            if (cfill_r < CAP_C) begin
              lm_we     = 1'b1;
              lm_waddr  = BASE_CACHE + LM_AW'(cfill_r);
              lm_wdata  = id_r;
              cfill_nxt = cfill_r + 1'b1;
            end
            state_nxt = S_DONE;
          end

          default: state_nxt = S_DONE;
        endcase
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_tier_nxt  = tier_r;
          unique case (tier_r)
            TIER_CACHE: out_lat_nxt = cache_lat_r;
            TIER_PAGE:  out_lat_nxt = page_lat_r;
            default:    out_lat_nxt = disk_lat_r;
          endcase
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_PRELOAD;
      stp_r       <= ST_SCAN_C;
      sel_r       <= L_CACHE;
      pre_addr_r  <= '0;
      cfill_r     <= CAP_C;
      pfill_r     <= CAP_P - CAP_C;
      dfill_r     <= CAP_D - CAP_P;
      out_valid_r <= 1'b0;
      cache_lat_r <= LAT_W'(1);
      page_lat_r  <= LAT_W'(10);
      disk_lat_r  <= LAT_W'(100);
    end else begin
      state_r     <= state_nxt;
      stp_r       <= stp_nxt;
      sel_r       <= sel_nxt;
      pre_addr_r  <= pre_addr_nxt;
      cfill_r     <= cfill_nxt;
      pfill_r     <= pfill_nxt;
      dfill_r     <= dfill_nxt;
      out_valid_r <= out_valid_nxt;
      cache_lat_r <= cache_lat_nxt;
      page_lat_r  <= page_lat_nxt;
      disk_lat_r  <= disk_lat_nxt;
    end
    id_r       <= id_nxt;
    tier_r     <= tier_nxt;
    found_r    <= found_nxt;
    i_r        <= i_nxt;
    pos_r      <= pos_nxt;
    best_pos_r <= best_pos_nxt;
    best_cnt_r <= best_cnt_nxt;
    best_id_r  <= best_id_nxt;
    cand_id_r  <= cand_id_nxt;
    out_tier_r <= out_tier_nxt;
    out_lat_r  <= out_lat_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_tier_found = out_tier_r;
  assign out_latency    = out_lat_r;
  assign cfg_ready      = 1'b1;

endmodule

### hdl/tlfu_checker.sv
// ----------------------------------------------------------------------------
// tlfu_checker
// Port-level checks of the three-tier store, bound to the top level.
// ----------------------------------------------------------------------------
module tlfu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_tier_found,
  input logic [9:0] out_latency
);

  // preload runs right after reset: no item taken, no result shown
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("item taken or result shown right after reset");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  // a result never appears in the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!(in_valid && !in_stall)))
    else $error("result raised one cycle after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_tier_found) && $stable(out_latency))
    else $error("stalled result changed");

endmodule

bind three_tier_lfu_storage tlfu_checker u_tlfu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_tier_found (out_tier_found),
  .out_latency    (out_latency)
);

### dv/three_tier_lfu_storage_test.sv
// ----------------------------------------------------------------------------
// three_tier_lfu_storage_test
// Drives address items through the three-tier store and checks the reported
// tier and latency against a cycle-free model of the tier lists and use
// counts. Latency registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module three_tier_lfu_storage_test;
  import tlfu_pkg::*;

  localparam int LVL_CACHE = 0;
  localparam int LVL_PAGE  = 1;
  localparam int LVL_DISK  = 2;
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int RANDOM_ITEMS = 700;

  typedef struct packed {
    tier_t tier;
    lat_t  lat;
  } access_result_t;

  typedef struct {
    logic [7:0]     addr;
    bit             typed;
    access_result_t res;
  } directed_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_address_id = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_tier_found;
  logic [9:0] out_latency;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  three_tier_lfu_storage i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model state
  id_t  tier_list[3][DISK_ENTRIES];
  int   tier_fill[3];
  int   tier_cap[3] = '{CACHE_ENTRIES, PAGE_ENTRIES, DISK_ENTRIES};
  cnt_t use_count[ADDRESS_IDS];
  lat_t lat_reg[3];

  access_result_t pending_results[$];
  int  mismatches = 0;
  bit  quiet = 1'b0;

  function automatic int find_pos(int t, id_t id);
    for (int i = 0; i < tier_fill[t]; i++) if (tier_list[t][i] == id) return i;
    return tier_fill[t];
  endfunction

  function automatic void drop_at(int t, int p);
    if (p >= tier_fill[t]) return;
    for (int i = p; i < tier_fill[t] - 1; i++) tier_list[t][i] = tier_list[t][i+1];
    tier_fill[t]--;
  endfunction

  function automatic void append(int t, id_t id);
    if (tier_fill[t] < tier_cap[t]) begin
      tier_list[t][tier_fill[t]] = id;
      tier_fill[t]++;
    end
  endfunction

  function automatic int least_used_pos(int t);
    int best = 0;
    for (int i = 1; i < tier_fill[t]; i++)
      if (use_count[tier_list[t][i]] < use_count[tier_list[t][best]]) best = i;
    return best;
  endfunction

  // move id into tier t, evicting the least used entry down one tier
  function automatic void promote(int t, id_t id);
    int v;
    drop_at(t + 1, find_pos(t + 1, id));
    if (tier_fill[t] >= tier_cap[t] && tier_fill[t] > 0) begin
      v = least_used_pos(t);
      append(t + 1, tier_list[t][v]);
      drop_at(t, v);
    end
    append(t, id);
  endfunction

  function automatic void preload_tiers();
    id_t id;
    tier_fill = '{0, 0, 0};
    foreach (use_count[i]) use_count[i] = '0;
    lat_reg = '{10'd1, 10'd10, 10'd100};
    for (int i = 0; i < DISK_ENTRIES; i++) begin
      id = id_t'(i % ADDRESS_IDS);
      append(LVL_DISK, id);
      if (i < PAGE_ENTRIES) begin
        promote(LVL_PAGE, id);
        if (i < CACHE_ENTRIES) promote(LVL_CACHE, id);
      end
    end
  endfunction

  function automatic access_result_t lookup_access(logic [7:0] raw);
    access_result_t r;
    id_t id = id_t'(raw % ADDRESS_IDS);
    if (use_count[id] != {COUNT_BITS{1'b1}}) use_count[id]++;
    if (find_pos(LVL_CACHE, id) < tier_fill[LVL_CACHE]) begin
      r.tier = TIER_CACHE;
      r.lat  = lat_reg[LVL_CACHE];
    end else if (find_pos(LVL_PAGE, id) < tier_fill[LVL_PAGE]) begin
      promote(LVL_CACHE, id);
      r.tier = TIER_PAGE;
      r.lat  = lat_reg[LVL_PAGE];
    end else begin
      if (find_pos(LVL_DISK, id) < tier_fill[LVL_DISK]) begin
        r.tier = TIER_DISK;
      end else begin
        // absent: drop the oldest disk entry to make room
        if (tier_fill[LVL_DISK] >= DISK_ENTRIES) drop_at(LVL_DISK, 0);
        append(LVL_DISK, id);
        r.tier = TIER_NONE;
      end
      promote(LVL_PAGE, id);
      promote(LVL_CACHE, id);
      r.lat = lat_reg[LVL_DISK];
    end
    return r;
  endfunction

  // result side: random stall, compare each accepted item
  always @(posedge clk) begin
    access_result_t e;
    out_stall <= !quiet && ($urandom_range(99) < 7);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result tier=%0d lat=%0d",
                                       out_tier_found, out_latency);
      end else begin
        e = pending_results.pop_front();
        if (out_tier_found !== e.tier || out_latency !== e.lat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp tier=%0d lat=%0d, got tier=%0d lat=%0d",
                     e.tier, e.lat, out_tier_found, out_latency);
        end
      end
    end
  end

  task automatic send_address(logic [7:0] addr, bit typed, access_result_t typed_res);
    access_result_t r;
    int gap = (quiet || $urandom_range(99) >= 7) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_address_id <= addr;
    do @(posedge clk); while (in_stall);
    r = lookup_access(addr);
    pending_results = {pending_results, (typed ? typed_res : r)};
  endtask

  task automatic write_latency(logic [1:0] idx, logic [9:0] value);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx != CFG_UNUSED_IDX) lat_reg[idx] = value;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_address();
    int sel = $urandom_range(99);
    if (sel < 45) return 8'($urandom_range(0, 47));
    if (sel < 70) return 8'($urandom_range(0, 11));
    return 8'($urandom_range(0, 255));
  endfunction

  directed_row_t directed[] = '{
    '{8'd0,   1'b1, '{TIER_CACHE, 10'd1}},
    '{8'd15,  1'b1, '{TIER_CACHE, 10'd1}},
    '{8'd16,  1'b1, '{TIER_PAGE,  10'd10}},
    '{8'd31,  1'b1, '{TIER_PAGE,  10'd10}},
    '{8'd32,  1'b1, '{TIER_DISK,  10'd100}},
    '{8'd63,  1'b1, '{TIER_DISK,  10'd100}},
    '{8'd255, 1'b1, '{TIER_NONE,  10'd100}},
    '{8'd64,  1'b1, '{TIER_NONE,  10'd100}},
    '{8'd0,   1'b0, '0}, '{8'd0,   1'b0, '0}, '{8'd1,   1'b0, '0},
    '{8'd2,   1'b0, '0}, '{8'd170, 1'b0, '0}, '{8'd85,  1'b0, '0},
    '{8'd128, 1'b0, '0}, '{8'd255, 1'b0, '0}, '{8'd33,  1'b0, '0},
    '{8'd34,  1'b0, '0}, '{8'd16,  1'b0, '0}, '{8'd200, 1'b0, '0},
    '{8'd127, 1'b0, '0}, '{8'd65,  1'b0, '0}
  };

  initial begin
    logic [9:0] settings[4][3] = '{
      '{10'd1023, 10'd1,    10'd1023},
      '{10'd1,    10'd1023, 10'd512},
      '{10'd7,    10'd300,  10'd1},
      '{10'd1,    10'd10,   10'd100}
    };
    preload_tiers();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_address(directed[i].addr, directed[i].typed, directed[i].res);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_latency(CFG_CACHE_LAT, settings[ph][0]);
      write_latency(CFG_PAGE_LAT,  settings[ph][1]);
      write_latency(CFG_DISK_LAT,  settings[ph][2]);
      if (ph == 2) write_latency(CFG_UNUSED_IDX, 10'h3FF);
      cfg_valid <= 1'b0;
      quiet = (ph == 1);
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        // hold off once until the store is empty of work
        if (ph == 0 && n == 20) drain();
        send_address(pick_address(), 1'b0, '0);
      end
      quiet = 1'b0;
      drain();
    end

    repeat (700) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS three_tier_lfu_storage");
    end else begin
      $display("FAIL three_tier_lfu_storage");
    end
    $finish;
  end

  initial begin
    #(8 * 3000000);
    $display("FAIL three_tier_lfu_storage");
    $finish;
  end

endmodule
